/* hdl/lbi2d_pkg.sv */
// Shared types and constants of the 2D bilinear lookup-table unit.
`timescale 1ns / 1ps
`default_nettype none
package lbi2d_pkg;

  localparam int VW      = 32;           // value width (signed fixed point)
  localparam int IDX_W   = 6;            // breakpoint / grid index width
  localparam int CNT_W   = IDX_W + 1;    // breakpoint count width
  localparam int MAX_X   = 1 << IDX_W;
  localparam int MAX_Y   = 1 << IDX_W;
  localparam int ZA_W    = 2 * IDX_W;    // grid address {row, col}
  localparam int Z_DEPTH = MAX_X * MAX_Y;
  localparam int WIDE_W  = 64;           // intermediate interpolation width
  localparam int D_W     = VW + 1;       // differences of two values
  localparam int MA_W    = WIDE_W - 1;   // magnitude of a wide operand
  localparam int P_W     = MA_W + D_W;   // full product width
  localparam int LIM_W   = 61;           // intermediate magnitude cap bits
  localparam int MD_CNT_W = $clog2(P_W);

  localparam logic signed [WIDE_W-1:0] INTER_LIM =
    (WIDE_W'(1) <<< LIM_W) - WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] V_MAX = (WIDE_W'(1) <<< (VW - 1)) - WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] V_MIN = -V_MAX - WIDE_W'(1);

  typedef enum logic [1:0] {
    CMD_LD_X  = 2'd0,
    CMD_LD_Y  = 2'd1,
    CMD_LD_Z  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ZERO_WIDTH = 2'd1,
    ST_SATURATED  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_NUM_X = 2'd0,
    REG_NUM_Y = 2'd1
  } reg_idx_t;

  typedef struct packed {
    cmd_t                   cmd;
    logic [IDX_W-1:0]       row_index;
    logic [IDX_W-1:0]       col_index;
    logic signed [VW-1:0]   load_value;
    logic signed [VW-1:0]   query_x;
    logic signed [VW-1:0]   query_y;
  } in_item_t;

  typedef struct packed {
    logic signed [VW-1:0]   interp_value;
    status_t                status;
    logic [IDX_W-1:0]       cell_row;
    logic [IDX_W-1:0]       cell_col;
  } out_item_t;

  // request as held in the queue between front and back
  typedef struct packed {
    cmd_t                   kind;
    logic [IDX_W-1:0]       row;
    logic [IDX_W-1:0]       col;
    logic signed [VW-1:0]   val_a;   // load value or query x
    logic signed [VW-1:0]   val_b;   // query y
  } q_entry_t;

  typedef struct packed {
    logic [CNT_W-1:0] num_x;
    logic [CNT_W-1:0] num_y;
  } cfg_t;

  function automatic logic signed [WIDE_W-1:0] clamp_inter(
    input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] r;
    if (v > INTER_LIM) r = INTER_LIM;
    else if (v < -INTER_LIM) r = -INTER_LIM;
    else r = v;
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/lbi2d_ram.sv */
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module lbi2d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* hdl/lbi2d_front.sv */
// Front stage: accepts requests, classifies them and hands them to the queue.
`timescale 1ns / 1ps
`default_nettype none
module lbi2d_front
  import lbi2d_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          push,
  output q_entry_t      push_data,
  input  wire logic     q_full
);

  logic     hold_r, hold_nxt;
  q_entry_t ent_r, ent_nxt;
  logic     take;

  assign push     = hold_r && !q_full;
  assign in_ready = !hold_r || !q_full;
  assign take     = in_valid && in_ready;

  always_comb begin
    ent_nxt       = ent_r;
    ent_nxt.kind  = in_data.cmd;
    ent_nxt.row   = in_data.row_index;
    ent_nxt.col   = in_data.col_index;
    if (in_data.cmd == CMD_QUERY) begin
      ent_nxt.val_a = in_data.query_x;
      ent_nxt.val_b = in_data.query_y;
    end else begin
      ent_nxt.val_a = in_data.load_value;
      ent_nxt.val_b = '0;
    end
    hold_nxt = take ? 1'b1 : (push ? 1'b0 : hold_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else begin
      hold_r <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ent_r <= ent_nxt;
    end
  end

  assign push_data = ent_r;

endmodule
`default_nettype wire

/* hdl/lbi2d_queue.sv */
// Two-entry request queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module lbi2d_queue
  import lbi2d_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire q_entry_t push_data,
  output logic          full,
  input  wire logic     pop,
  output logic          not_empty,
  output q_entry_t      head
);

  q_entry_t   ent_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = ent_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");

endmodule
`default_nettype wire

/* hdl/lbi2d_muldiv.sv */
// Bit-serial trunc(a*b/d) with the magnitude capped at 2^61-1.
`timescale 1ns / 1ps
`default_nettype none
module lbi2d_muldiv
  import lbi2d_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [WIDE_W-1:0] a,
  input  wire logic signed [D_W-1:0]    b,
  input  wire logic signed [D_W-1:0]    d,
  output logic                          done,
  output logic signed [WIDE_W-1:0]      res
);

  typedef enum logic [3:0] {
    MD_IDLE = 4'b0001,
    MD_MUL  = 4'b0010,
    MD_DIV  = 4'b0100,
    MD_FIN  = 4'b1000
  } md_state_t;

  md_state_t             state_r, state_nxt;
  logic [MD_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                  done_r, done_nxt;
  logic [MA_W-1:0]       ma_r;
  logic [D_W-1:0]        mb_r, md_r;
  logic                  neg_r;
  logic [P_W-1:0]        prod_r, prod_nxt;
  logic [D_W-1:0]        rem_r, rem_nxt;
  logic signed [WIDE_W-1:0] res_r;

  logic [WIDE_W-1:0]     a_mag;
  logic [D_W-1:0]        b_mag, d_mag;
  logic [D_W:0]          rem_sh, rem_sub;
  logic                  ge, ovf;
  logic [WIDE_W-1:0]     q_mag;

  always_comb begin
    a_mag   = a[WIDE_W-1] ? WIDE_W'(-a) : WIDE_W'(a);
    b_mag   = b[D_W-1] ? D_W'(-b) : D_W'(b);
    d_mag   = d[D_W-1] ? D_W'(-d) : D_W'(d);
    rem_sh  = {rem_r, prod_r[P_W-1]};
    rem_sub = rem_sh - {1'b0, md_r};
    ge      = (rem_sh >= {1'b0, md_r});
    ovf     = |prod_r[P_W-1:LIM_W];
    q_mag   = ovf ? WIDE_W'(INTER_LIM) : WIDE_W'(prod_r[LIM_W-1:0]);

    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    unique case (state_r)
      MD_IDLE: begin
        if (start) begin
          state_nxt = MD_MUL;
          cnt_nxt   = MD_CNT_W'(D_W - 1);
          prod_nxt  = '0;
          rem_nxt   = '0;
        end
      end
      MD_MUL: begin
        // MSB-first shift-add over the bits of |b|
        prod_nxt = (prod_r << 1) + (mb_r[D_W-1] ? P_W'(ma_r) : '0);
        if (cnt_r == '0) begin
          state_nxt = MD_DIV;
          cnt_nxt   = MD_CNT_W'(P_W - 1);
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      MD_DIV: begin
        // restoring division; quotient bits fill the product register
        prod_nxt = {prod_r[P_W-2:0], ge};
        rem_nxt  = ge ? rem_sub[D_W-1:0] : rem_sh[D_W-1:0];
        if (cnt_r == '0) begin
          state_nxt = MD_FIN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      MD_FIN: begin
        state_nxt = MD_IDLE;
        done_nxt  = 1'b1;
      end
      default: begin
        state_nxt = MD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    if (state_r == MD_IDLE && start) begin
      ma_r  <= a_mag[MA_W-1:0];
      mb_r  <= b_mag;
      md_r  <= d_mag;
      neg_r <= a[WIDE_W-1] ^ b[D_W-1] ^ d[D_W-1];
    end else if (state_r == MD_MUL) begin
      mb_r <= mb_r << 1;
    end
    if (state_r == MD_FIN) begin
      res_r <= neg_r ? -$signed(q_mag) : $signed(q_mag);
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
`default_nettype wire

/* hdl/lbi2d_back.sv */
// Back stage: table writes, breakpoint search, corner fetch and interpolation.
`timescale 1ns / 1ps
`default_nettype none
module lbi2d_back
  import lbi2d_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cfg_t     cfg,
  input  wire logic     q_not_empty,
  input  wire q_entry_t q_head,
  output logic          pop,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SRCH   = 7'b0000010,
    S_SCMP   = 7'b0000100,
    S_FETCH  = 7'b0001000,
    S_CHECK  = 7'b0010000,
    S_CALC   = 7'b0100000,
    S_RESULT = 7'b1000000
  } bk_state_t;

  typedef enum logic [1:0] {
    OP_ROW0 = 2'd0,
    OP_ROW1 = 2'd1,
    OP_COL  = 2'd2
  } op_t;

  bk_state_t state_r, state_nxt;
  op_t       op_r, op_nxt, start_op;
  logic [CNT_W-1:0] lo_x_r, hi_x_r, lo_y_r, hi_y_r;
  logic [CNT_W-1:0] lo_x_nxt, hi_x_nxt, lo_y_nxt, hi_y_nxt;
  logic [2:0] fc_r, fc_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  logic signed [VW-1:0] qx_r, qy_r, xa_r, xb_r, ya_r, yb_r;
  logic signed [VW-1:0] z00_r, z01_r, z10_r, z11_r;
  logic signed [WIDE_W-1:0] ri_r;
  logic signed [VW-1:0] res_val_r;
  status_t res_st_r;

  // search
  logic [CNT_W-1:0] diff_x, diff_y, s_x, s_y, probe_x, probe_y;
  logic act_x, act_y;

  // memories
  logic             we_x, we_y, we_z;
  logic [IDX_W-1:0] addr_x, addr_y, zr, zc;
  logic [ZA_W-1:0]  addr_z;
  logic [VW-1:0]    x_rd, y_rd, z_rd;
  logic [IDX_W-1:0] i_idx, j_idx;

  // arithmetic
  logic signed [D_W-1:0]    dx, dy, tx, ty, dz0, dz1;
  logic signed [WIDE_W-1:0] md_a, md_res, ri_c, rn_c, v_sum;
  logic signed [D_W-1:0]    md_b, md_d;
  logic                     md_start, md_done, zero_w;

  assign i_idx = lo_x_r[IDX_W-1:0];
  assign j_idx = lo_y_r[IDX_W-1:0];

  always_comb begin
    diff_x  = hi_x_r - lo_x_r;
    diff_y  = hi_y_r - lo_y_r;
    act_x   = diff_x > CNT_W'(1);
    act_y   = diff_y > CNT_W'(1);
    s_x     = diff_x >> 1;
    s_y     = diff_y >> 1;
    probe_x = lo_x_r + s_x;
    probe_y = lo_y_r + s_y;
  end

  assign pop  = (state_r == S_IDLE) && q_not_empty;
  assign we_x = pop && (q_head.kind == CMD_LD_X);
  assign we_y = pop && (q_head.kind == CMD_LD_Y);
  assign we_z = pop && (q_head.kind == CMD_LD_Z);

  always_comb begin
    zr = fc_r[1] ? i_idx + 1'b1 : i_idx;
    zc = fc_r[0] ? j_idx + 1'b1 : j_idx;
    priority if (state_r == S_IDLE) begin
      addr_x = q_head.row;
      addr_y = q_head.col;
      addr_z = {q_head.row, q_head.col};
    end else if (state_r == S_FETCH) begin
      addr_x = (fc_r == 3'd0) ? i_idx : i_idx + 1'b1;
      addr_y = (fc_r == 3'd0) ? j_idx : j_idx + 1'b1;
      addr_z = {zr, zc};
    end else begin
      addr_x = probe_x[IDX_W-1:0];
      addr_y = probe_y[IDX_W-1:0];
      addr_z = {zr, zc};
    end
  end

  lbi2d_ram #(.WIDTH(VW), .DEPTH(MAX_X)) u_x_ram (
    .clk(clk), .we(we_x), .addr(addr_x), .wdata(q_head.val_a), .rdata(x_rd)
  );
  lbi2d_ram #(.WIDTH(VW), .DEPTH(MAX_Y)) u_y_ram (
    .clk(clk), .we(we_y), .addr(addr_y), .wdata(q_head.val_a), .rdata(y_rd)
  );
  lbi2d_ram #(.WIDTH(VW), .DEPTH(Z_DEPTH)) u_z_ram (
    .clk(clk), .we(we_z), .addr(addr_z), .wdata(q_head.val_a), .rdata(z_rd)
  );

  always_comb begin
    dx     = D_W'(xb_r) - D_W'(xa_r);
    dy     = D_W'(yb_r) - D_W'(ya_r);
    tx     = D_W'(qx_r) - D_W'(xa_r);
    ty     = D_W'(qy_r) - D_W'(ya_r);
    dz0    = D_W'(z01_r) - D_W'(z00_r);
    dz1    = D_W'(z11_r) - D_W'(z10_r);
    zero_w = (dx == '0) || (dy == '0);
    ri_c   = clamp_inter(WIDE_W'(z00_r) + md_res);
    rn_c   = clamp_inter(WIDE_W'(z10_r) + md_res);
    v_sum  = ri_r + md_res;

    priority if (state_r == S_CALC && md_done && op_r == OP_ROW0) begin
      start_op = OP_ROW1;
    end else if (state_r == S_CALC && md_done && op_r == OP_ROW1) begin
      start_op = OP_COL;
    end else begin
      start_op = OP_ROW0;
    end
    md_start = ((state_r == S_CHECK) && !zero_w)
            || ((state_r == S_CALC) && md_done && (op_r != OP_COL));

    unique case (start_op)
      OP_ROW0: begin
        md_a = WIDE_W'(dz0);
        md_b = ty;
        md_d = dy;
      end
      OP_ROW1: begin
        md_a = WIDE_W'(dz1);
        md_b = ty;
        md_d = dy;
      end
      default: begin
        md_a = rn_c - ri_r;
        md_b = tx;
        md_d = dx;
      end
    endcase
  end

  lbi2d_muldiv u_muldiv (
    .clk(clk), .rst_n(rst_n), .start(md_start), .a(md_a), .b(md_b), .d(md_d),
    .done(md_done), .res(md_res)
  );

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    lo_x_nxt  = lo_x_r;
    hi_x_nxt  = hi_x_r;
    lo_y_nxt  = lo_y_r;
    hi_y_nxt  = hi_y_r;
    fc_nxt    = fc_r;
    out_valid_nxt = (out_valid_r && out_ready) ? 1'b0 : out_valid_r;
    unique case (state_r)
      S_IDLE: begin
        if (pop && q_head.kind == CMD_QUERY) begin
          state_nxt = S_SRCH;
          lo_x_nxt  = '0;
          hi_x_nxt  = cfg.num_x - 1'b1;
          lo_y_nxt  = '0;
          hi_y_nxt  = cfg.num_y - 1'b1;
        end
      end
      S_SRCH: begin
        if (!act_x && !act_y) begin
          state_nxt = S_FETCH;
          fc_nxt    = '0;
        end else begin
          state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        state_nxt = S_SRCH;
        if (act_x) begin
          if (qx_r >= $signed(x_rd)) lo_x_nxt = lo_x_r + s_x;
          else hi_x_nxt = hi_x_r - s_x;
        end
        if (act_y) begin
          if (qy_r >= $signed(y_rd)) lo_y_nxt = lo_y_r + s_y;
          else hi_y_nxt = hi_y_r - s_y;
        end
      end
      S_FETCH: begin
        fc_nxt = fc_r + 1'b1;
        if (fc_r == 3'd4) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (zero_w) begin
          state_nxt = S_RESULT;
        end else begin
          state_nxt = S_CALC;
          op_nxt    = OP_ROW0;
        end
      end
      S_CALC: begin
        if (md_done) begin
          if (op_r == OP_COL) state_nxt = S_RESULT;
          else op_nxt = start_op;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      op_r        <= OP_ROW0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      op_r        <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_x_r <= lo_x_nxt;
    hi_x_r <= hi_x_nxt;
    lo_y_r <= lo_y_nxt;
    hi_y_r <= hi_y_nxt;
    fc_r   <= fc_nxt;
    if (pop && q_head.kind == CMD_QUERY) begin
      qx_r <= q_head.val_a;
      qy_r <= q_head.val_b;
    end
    if (state_r == S_FETCH) begin
      unique case (fc_r)
        3'd1: begin
          xa_r  <= x_rd;
          ya_r  <= y_rd;
          z00_r <= z_rd;
        end
        3'd2: begin
          xb_r  <= x_rd;
          yb_r  <= y_rd;
          z01_r <= z_rd;
        end
        3'd3: z10_r <= z_rd;
        3'd4: z11_r <= z_rd;
        default: ;
      endcase
    end
    if (state_r == S_CHECK && zero_w) begin
      res_val_r <= '0;
      res_st_r  <= ST_ZERO_WIDTH;
    end
    if (state_r == S_CALC && md_done) begin
      if (op_r == OP_ROW0) begin
        ri_r <= ri_c;
      end else if (op_r == OP_COL) begin
        if (v_sum > V_MAX) begin
          res_val_r <= V_MAX[VW-1:0];
          res_st_r  <= ST_SATURATED;
        end else if (v_sum < V_MIN) begin
          res_val_r <= V_MIN[VW-1:0];
          res_st_r  <= ST_SATURATED;
        end else begin
          res_val_r <= v_sum[VW-1:0];
          res_st_r  <= ST_OK;
        end
      end
    end
    if (state_r == S_RESULT && (!out_valid_r || out_ready)) begin
      out_data_r.interp_value <= res_val_r;
      out_data_r.status       <= res_st_r;
      out_data_r.cell_row     <= i_idx;
      out_data_r.cell_col     <= j_idx;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_search_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FETCH) |-> (hi_x_r == lo_x_r + CNT_W'(1))
                          && (hi_y_r == lo_y_r + CNT_W'(1)))
    else $error("search ended with an open interval");
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    md_start |-> (md_d != '0)) else $error("divider started with zero width");
  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    md_done |-> (state_r == S_CALC)) else $error("divider result outside calc");

endmodule
`default_nettype wire

/* hdl/lut_bilinear_interp_2d_unit.sv */
// Top level of the 2D bilinear lookup-table unit.
// Load requests: one per cycle while no query busies the back stage; the write lands in
//   the table RAM after the front holding register and the queue. Query requests: search,
//   corner fetch, then for a nonzero-width cell three multiply-divide runs; one at a time.
// Reset (synchronous, rst_n low) clears control state and sets both counts to 2;
//   table contents stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module lut_bilinear_interp_2d_unit
  import lbi2d_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CNT_W-1:0] cfg_data
);

  cfg_t     cfg_r, cfg_nxt;
  logic     push, q_full, pop, q_not_empty;
  q_entry_t push_data, q_head;
  logic [CNT_W-1:0] cnt_x, cnt_y;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (cfg_data < CNT_W'(2)) cnt_x = CNT_W'(2);
    else if (cfg_data > CNT_W'(MAX_X)) cnt_x = CNT_W'(MAX_X);
    else cnt_x = cfg_data;
    if (cfg_data < CNT_W'(2)) cnt_y = CNT_W'(2);
    else if (cfg_data > CNT_W'(MAX_Y)) cnt_y = CNT_W'(MAX_Y);
    else cnt_y = cfg_data;
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      if (cfg_index == REG_NUM_X) cfg_nxt.num_x = cnt_x;
      else if (cfg_index == REG_NUM_Y) cfg_nxt.num_y = cnt_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_x <= CNT_W'(2);
      cfg_r.num_y <= CNT_W'(2);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lbi2d_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .push(push), .push_data(push_data), .q_full(q_full)
  );

  lbi2d_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data), .full(q_full),
    .pop(pop), .not_empty(q_not_empty), .head(q_head)
  );

  lbi2d_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_not_empty(q_not_empty),
    .q_head(q_head), .pop(pop), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

endmodule
`default_nettype wire

/* dv/lbi2d_checker.sv */
// Checker for the 2D bilinear lookup-table unit: predicts query results and compares.
`timescale 1ns / 1ps
module lbi2d_checker
  import lbi2d_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  in_item_t         in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_item_t        out_data,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [CNT_W-1:0] cfg_data,
  output int               errors,
  output int               pending
);

  longint      x_bp [MAX_X];
  longint      y_bp [MAX_Y];
  longint      z_tab [Z_DEPTH];
  int unsigned rows_used;
  int unsigned cols_used;
  out_item_t   awaited_results [$];

  function automatic int unsigned clip_count(input logic [CNT_W-1:0] raw);
    if (raw < 2) return 2;
    if (raw > MAX_X) return MAX_X;
    return raw;
  endfunction

  function automatic int unsigned cell_of(input longint bp [64], input int unsigned n,
                                          input longint q);
    int unsigned lo;
    int unsigned hi;
    int unsigned s;
    lo = 0;
    hi = n - 1;
    while (hi - lo > 1) begin
      s = (hi - lo) / 2;
      if (q >= bp[lo + s]) lo += s;
      else hi -= s;
    end
    if (lo > n - 2) lo = n - 2;
    return lo;
  endfunction

  // trunc(a*b/d), magnitude capped at the intermediate limit
  function automatic longint scaled_quot(input longint a, input longint b, input longint d);
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [63:0]  md;
    logic [127:0] quot;
    longint       r;
    bit           neg;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    md = (d < 0) ? -d : d;
    quot = ({64'd0, ma} * {64'd0, mb}) / {64'd0, md};
    if (quot > 128'(INTER_LIM)) quot = 128'(INTER_LIM);
    r = quot[63:0];
    neg = ((a < 0) != (b < 0)) != (d < 0);
    if (a == 0 || b == 0) neg = 0;
    return neg ? -r : r;
  endfunction

  function automatic longint clip_inter(input longint v);
    if (v > INTER_LIM) return INTER_LIM;
    if (v < -INTER_LIM) return -INTER_LIM;
    return v;
  endfunction

  function automatic out_item_t interpolate(input in_item_t it);
    out_item_t   res;
    int unsigned i;
    int unsigned j;
    longint      qx;
    longint      qy;
    longint      dx;
    longint      dy;
    longint      ty;
    longint      r_lo;
    longint      r_hi;
    longint      v;
    qx = longint'(it.query_x);
    qy = longint'(it.query_y);
    i = cell_of(x_bp, rows_used, qx);
    j = cell_of(y_bp, cols_used, qy);
    dx = x_bp[i + 1] - x_bp[i];
    dy = y_bp[j + 1] - y_bp[j];
    res.cell_row = i[IDX_W-1:0];
    res.cell_col = j[IDX_W-1:0];
    res.status = ST_OK;
    v = 0;
    if (dx == 0 || dy == 0) begin
      res.status = ST_ZERO_WIDTH;
    end else begin
      ty = qy - y_bp[j];
      r_lo = clip_inter(z_tab[i * MAX_Y + j] +
        scaled_quot(z_tab[i * MAX_Y + j + 1] - z_tab[i * MAX_Y + j], ty, dy));
      r_hi = clip_inter(z_tab[(i + 1) * MAX_Y + j] +
        scaled_quot(z_tab[(i + 1) * MAX_Y + j + 1] - z_tab[(i + 1) * MAX_Y + j], ty, dy));
      v = r_lo + scaled_quot(r_hi - r_lo, qx - x_bp[i], dx);
      if (v > V_MAX) begin
        v = V_MAX;
        res.status = ST_SATURATED;
      end else if (v < V_MIN) begin
        v = V_MIN;
        res.status = ST_SATURATED;
      end
    end
    res.interp_value = v[VW-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      rows_used = 2;
      cols_used = 2;
      awaited_results.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_NUM_X) rows_used = clip_count(cfg_data);
        else if (cfg_index == REG_NUM_Y) cols_used = clip_count(cfg_data);
      end
      if (in_valid && in_ready) begin
        case (in_data.cmd)
          CMD_LD_X: x_bp[in_data.row_index] = longint'(in_data.load_value);
          CMD_LD_Y: y_bp[in_data.col_index] = longint'(in_data.load_value);
          CMD_LD_Z: z_tab[in_data.row_index * MAX_Y + in_data.col_index] =
                      longint'(in_data.load_value);
          default: awaited_results.push_back(interpolate(in_data));
        endcase
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result value %0d status %0d",
                                     out_data.interp_value, out_data.status);
        end else begin
          want = awaited_results.pop_front();
          if (want.interp_value !== out_data.interp_value || want.status !== out_data.status ||
              want.cell_row !== out_data.cell_row || want.cell_col !== out_data.cell_col) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected value %0d status %0d cell %0d,%0d; got %0d %0d %0d,%0d",
                       want.interp_value, want.status, want.cell_row, want.cell_col,
                       out_data.interp_value, out_data.status, out_data.cell_row,
                       out_data.cell_col);
          end
        end
      end
    end
    pending = awaited_results.size();
  end

endmodule

/* dv/tb_lut_bilinear_interp_2d_unit.sv */
// Testbench top of the 2D bilinear lookup-table unit: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb_lut_bilinear_interp_2d_unit;
  import lbi2d_pkg::*;

  localparam int          STALL_LIMIT = 20000;
  localparam logic [1:0]  REG_SPARE_LO = 2'd2;  // indexes beyond the register list
  localparam logic [1:0]  REG_SPARE_HI = 2'd3;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = '0;
  logic [CNT_W-1:0] cfg_data = '0;
  int               errors;
  int               pending;
  int               snd_idle = 26;
  int               rcv_idle = 78;
  int               quiet_cycles = 0;

  // stimulus-side copy of the breakpoints, used to aim queries
  longint      x_shadow [64];
  longint      y_shadow [64];
  int unsigned rows_used = 2;
  int unsigned cols_used = 2;

  always #10 clk = ~clk;

  lut_bilinear_interp_2d_unit dut (.*);

  lbi2d_checker checker_i (.*);

  always @(posedge clk) out_ready <= (rcv_idle == 0) || ($urandom_range(99) >= rcv_idle);

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (quiet_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  task automatic push(input cmd_t cmd, input int row, input int col, input longint val,
                      input longint qx, input longint qy);
    in_item_t it;
    it.cmd = cmd;
    it.row_index = row[IDX_W-1:0];
    it.col_index = col[IDX_W-1:0];
    it.load_value = val[VW-1:0];
    it.query_x = qx[VW-1:0];
    it.query_y = qy[VW-1:0];
    while (snd_idle != 0 && $urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic load(input cmd_t cmd, input int row, input int col, input longint val);
    if (cmd == CMD_LD_X) x_shadow[row] = val;
    if (cmd == CMD_LD_Y) y_shadow[col] = val;
    push(cmd, row, col, val, int'($urandom), int'($urandom));
  endtask

  task automatic query(input longint qx, input longint qy);
    push(CMD_QUERY, $urandom_range(63), $urandom_range(63), int'($urandom), qx, qy);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (450) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int unsigned clip_count(input int raw);
    return (raw < 2) ? 2 : (raw > 64) ? 64 : raw;
  endfunction

  function automatic longint pick_value();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 50) return longint'($urandom_range(1 << 20)) - (1 << 19);
    if (sel < 90) return longint'($urandom_range(1 << 28)) - (1 << 27);
    return longint'(int'($urandom));
  endfunction

  function automatic longint aim(input longint bp [64], input int unsigned n);
    longint lo;
    longint hi;
    longint span;
    longint v;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 10) return longint'(int'($urandom));
    if (sel < 25) return bp[$urandom_range(n - 1)];
    lo = bp[0];
    hi = bp[n - 1];
    if (hi < lo) begin
      v = lo;
      lo = hi;
      hi = v;
    end
    span = (hi - lo) / 4 + 1;
    lo -= span;
    hi += span;
    v = lo + longint'({$urandom, $urandom} % 64'(hi - lo + 1));
    if (v > V_MAX) v = V_MAX;
    if (v < V_MIN) v = V_MIN;
    return v;
  endfunction

  task automatic fill_axis(input cmd_t cmd, input int unsigned n);
    int     step_max;
    longint v;
    step_max = 1 << (4 + 4 * $urandom_range(5));
    v = -(longint'(n) * step_max / 2) + longint'($urandom_range(255));
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 3) load(cmd, k, k, longint'(int'($urandom)));
      else load(cmd, k, k, v);
      v += ($urandom_range(99) < 5) ? 0 : $urandom_range(step_max, 1);
    end
  endtask

  task automatic run_setting(input int raw_rows, input int raw_cols, input int queries);
    drain();
    write_reg(REG_NUM_X, raw_rows[CNT_W-1:0]);
    write_reg(REG_NUM_Y, raw_cols[CNT_W-1:0]);
    write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, CNT_W'($urandom));
    rows_used = clip_count(raw_rows);
    cols_used = clip_count(raw_cols);
    fill_axis(CMD_LD_X, rows_used);
    fill_axis(CMD_LD_Y, cols_used);
    for (int r = 0; r < rows_used; r++)
      for (int c = 0; c < cols_used; c++) load(CMD_LD_Z, r, c, pick_value());
    for (int k = 0; k < queries; k++) begin
      case ($urandom_range(19))
        0: load(CMD_LD_X, $urandom_range(63), 0, aim(x_shadow, rows_used));
        1: load(CMD_LD_Y, 0, $urandom_range(63), aim(y_shadow, cols_used));
        2, 3: load(CMD_LD_Z, $urandom_range(63), $urandom_range(63), pick_value());
        default: query(aim(x_shadow, rows_used), aim(y_shadow, cols_used));
      endcase
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unit square at reset counts, then extremes, saturation and zero-width cells
    load(CMD_LD_X, 0, 0, 0);
    load(CMD_LD_X, 1, 0, 1 << 16);
    load(CMD_LD_Y, 0, 0, 0);
    load(CMD_LD_Y, 0, 1, 1 << 16);
    load(CMD_LD_Z, 0, 0, 0);
    load(CMD_LD_Z, 0, 1, 1 << 16);
    load(CMD_LD_Z, 1, 0, 2 << 16);
    load(CMD_LD_Z, 1, 1, 3 << 16);
    query(0, 0);
    query(1 << 15, 1 << 15);
    query(1 << 16, 1 << 16);
    query(V_MIN, V_MIN);
    query(V_MAX, V_MAX);
    query(V_MAX, V_MIN);
    load(CMD_LD_Z, 1, 1, V_MAX);
    load(CMD_LD_Z, 1, 0, V_MIN);
    query(V_MAX, V_MAX);
    query(-(1 << 20), 1 << 14);
    load(CMD_LD_X, 1, 0, 0);
    query(1 << 15, 1 << 15);
    load(CMD_LD_X, 1, 0, 1 << 16);
    load(CMD_LD_Y, 0, 1, 0);
    query(1 << 15, 1 << 15);
    load(CMD_LD_X, 63, 0, V_MAX);
    load(CMD_LD_Z, 63, 63, V_MIN);

    run_setting(1, 0, 160);
    run_setting(9, 5, 160);
    snd_idle = 78;
    rcv_idle = 26;
    run_setting(64, 3, 160);
    run_setting(3, 64, 160);
    snd_idle = 0;
    rcv_idle = 0;
    run_setting(100, 3, 160);
    run_setting(2, 127, 160);

    drain();
    if (errors == 0 && pending == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
